// ===== design/hbk_pkg.sv =====
package hbk_pkg;

  localparam int NUM_SOURCES_DEF = 2;
  localparam int KEYS = 6;
  // Each item has up to KEYS release slots followed by KEYS press slots.
  localparam int SLOTS = 2 * KEYS;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int QDEPTH = 2;

  localparam logic [7:0] KEY_CAPS = 8'h39;
  localparam logic [7:0] KEY_NUM = 8'h53;
  localparam logic [7:0] KP_FIRST = 8'h59;
  localparam logic [7:0] KP_LAST = 8'h63;
  localparam logic [7:0] ROLL_LO = 8'h01;
  localparam logic [7:0] ROLL_HI = 8'h03;

  typedef enum logic [2:0] {
    EV_UP      = 3'd0,
    EV_DOWN    = 3'd1,
    EV_NUMTOG  = 3'd2,
    EV_CAPSTOG = 3'd3,
    EV_DISC    = 3'd4,
    EV_END     = 3'd5
  } ev_kind_t;

  // One classified report, waiting for the back end to emit its events.
  typedef struct packed {
    logic                   src;
    logic [7:0]             mods;
    logic                   disc;
    logic                   seen;
    logic [SLOTS-1:0]       mask;
    logic [SLOTS-1:0][2:0]  kind;
    logic [SLOTS-1:0][7:0]  usage;
  } evq_entry_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic       src;
    logic [7:0] usage;
    logic [7:0] mods;
    logic       seen;
    logic       last;
  } evt_t;

  // With num lock off, keypad usages turn into navigation keys.
  function automatic logic [7:0] kp_remap(input logic [7:0] usage, input logic num_on);
    logic [7:0] r;
    r = usage;
    if (!num_on) begin
      case (usage)
        8'h59: r = 8'h4D;
        8'h5A: r = 8'h51;
        8'h5B: r = 8'h4E;
        8'h5C: r = 8'h50;
        8'h5D: r = 8'h5D;
        8'h5E: r = 8'h4F;
        8'h5F: r = 8'h4A;
        8'h60: r = 8'h52;
        8'h61: r = 8'h4B;
        8'h62: r = 8'h49;
        8'h63: r = 8'h4C;
        default: r = usage;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== design/hbk_front.sv =====
module hbk_front import hbk_pkg::*; #(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic                  in_src,
  input  logic [7:0]            in_mods,
  input  logic [KEYS-1:0][7:0]  in_keys,
  input  logic                  q_ready,
  output logic                  push,
  output evq_entry_t            entry
);

  localparam int ROW_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  logic [KEYS-1:0][7:0] prev [NUM_SOURCES];
  logic [1:0]           num_lock;
  logic [KEYS-1:0][7:0] prev_row;
  logic [ROW_W-1:0]     row;
  logic                 src_ok;
  logic                 num_on;
  logic                 roll;
  logic                 disc;
  logic                 accept;
  logic                 hit;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign src_ok   = (NUM_SOURCES > 1) || (in_src == 1'b0);
  assign push     = accept && src_ok;
  assign row      = ROW_W'(in_src);
  assign prev_row = src_ok ? prev[row] : '0;
  assign num_on   = num_lock[in_src];

  always_comb begin
    roll = 1'b0;
    for (int i = 0; i < KEYS; i++) begin
      if (in_keys[i] >= ROLL_LO && in_keys[i] <= ROLL_HI) begin
        roll = 1'b1;
      end
    end
  end

  assign disc = in_mode || roll;

  always_comb begin
    entry      = '0;
    entry.src  = in_src;
    entry.mods = in_mods;
    entry.disc = disc;
    // Releases: old usages missing from the new report, lock keys excluded.
    for (int i = 0; i < KEYS; i++) begin
      hit = 1'b0;
      for (int j = 0; j < KEYS; j++) begin
        if (in_keys[j] == prev_row[i]) begin
          hit = 1'b1;
        end
      end
      entry.kind[i]  = EV_UP;
      entry.usage[i] = kp_remap(prev_row[i], num_on);
      entry.mask[i]  = !disc && prev_row[i] != 8'h00 && !hit &&
                       prev_row[i] != KEY_NUM && prev_row[i] != KEY_CAPS;
    end
    // Presses: new usages missing from the old report.
    for (int i = 0; i < KEYS; i++) begin
      hit = 1'b0;
      for (int j = 0; j < KEYS; j++) begin
        if (prev_row[j] == in_keys[i]) begin
          hit = 1'b1;
        end
      end
      entry.mask[KEYS+i] = !disc && in_keys[i] != 8'h00 && !hit;
      if (in_keys[i] == KEY_NUM) begin
        entry.kind[KEYS+i]  = EV_NUMTOG;
        entry.usage[KEYS+i] = 8'h00;
      end else if (in_keys[i] == KEY_CAPS) begin
        entry.kind[KEYS+i]  = EV_CAPSTOG;
        entry.usage[KEYS+i] = 8'h00;
      end else begin
        entry.kind[KEYS+i]  = EV_DOWN;
        entry.usage[KEYS+i] = kp_remap(in_keys[i], num_on);
      end
    end
    entry.seen = |entry.mask[SLOTS-1:KEYS];
  end

  // The stored row is updated as the item is taken, so a following item of
  // the same source already compares against this report.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_lock <= '0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        prev[s] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        num_lock <= cfg_wr_data;
      end
      if (push) begin
        prev[row] <= disc ? '0 : in_keys;
      end
    end
  end

endmodule

// ===== design/hbk_queue.sv =====
module hbk_queue import hbk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  evq_entry_t wr_entry,
  output logic       not_full,
  input  logic       pop,
  output evq_entry_t head,
  output logic       head_valid
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  evq_entry_t       mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign not_full   = count != CNT_W'(QDEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (!push && pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // Depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

// ===== design/hbk_back.sv =====
module hbk_back import hbk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  evq_entry_t head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output evt_t       out_evt
);

  logic [SLOTS-1:0]  pend;
  logic [SLOTS-1:0]  pend_cur;
  logic [SLOTS-1:0]  pend_next;
  logic              started;
  logic [SLOT_W-1:0] idx;
  logic              can_load;
  logic              fire;
  logic              any_left;
  evt_t              evt_next;

  assign can_load = !out_valid || out_ready;
  assign fire     = head_valid && can_load;
  assign pend_cur = started ? pend : head.mask;
  assign any_left = pend_cur != '0;
  assign pop      = fire && !any_left;

  always_comb begin
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pend_cur[i]) begin
        idx = SLOT_W'(i);
      end
    end
  end

  assign pend_next = pend_cur & ~(SLOTS'(1) << idx);

  always_comb begin
    evt_next.src = head.src;
    if (any_left) begin
      evt_next.kind  = ev_kind_t'(head.kind[idx]);
      evt_next.usage = head.usage[idx];
      evt_next.mods  = head.mods;
      evt_next.seen  = 1'b0;
      evt_next.last  = 1'b0;
    end else if (head.disc) begin
      evt_next.kind  = EV_DISC;
      evt_next.usage = 8'h00;
      evt_next.mods  = 8'h00;
      evt_next.seen  = 1'b0;
      evt_next.last  = 1'b1;
    end else begin
      evt_next.kind  = EV_END;
      evt_next.usage = 8'h00;
      evt_next.mods  = head.mods;
      evt_next.seen  = head.seen;
      evt_next.last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_evt <= evt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      started   <= 1'b0;
      pend      <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        started   <= any_left;
        pend      <= pend_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/hid_boot_report_key_event_differ.sv =====
// Turns boot keyboard reports into key events. Each accepted item yields its
// key-up events (old slot order), then key-down or lock-toggle events (new
// slot order), then one report-end record with tlast set; a disconnect or a
// rollover code yields a single disconnect record instead. Items are taken
// one per cycle into a two-entry queue while it has room; the event
// sequencer behind it emits one result per cycle while the output is not
// stalled, so an item yields 1 + (number of releases and presses) results,
// 1 to 13. A source index at or above NUM_SOURCES is accepted and dropped without output.
module hid_boot_report_key_event_differ import hbk_pkg::*; #(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,     // num_lock_mask
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,    // modifier_byte, key0 .. key5
  input  logic [1:0]  s_axis_tuser,    // mode, source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // key_usage, event_modifiers, new_press_seen, pad
  output logic [3:0]  m_axis_tuser,    // event_kind, event_source
  output logic        m_axis_tlast     // last_event
);

  logic       push;
  logic       pop;
  logic       q_not_full;
  logic       head_valid;
  evq_entry_t wr_entry;
  evq_entry_t head;
  evt_t       out_evt;

  hbk_front #(.NUM_SOURCES(NUM_SOURCES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_mode     (s_axis_tuser[0]),
    .in_src      (s_axis_tuser[1]),
    .in_mods     (s_axis_tdata[7:0]),
    .in_keys     (s_axis_tdata[55:8]),
    .q_ready     (q_not_full),
    .push        (push),
    .entry       (wr_entry)
  );

  hbk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (wr_entry),
    .not_full   (q_not_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  hbk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_evt    (out_evt)
  );

  assign m_axis_tdata = {7'b0, out_evt.seen, out_evt.mods, out_evt.usage};
  assign m_axis_tuser = {out_evt.src, out_evt.kind};
  assign m_axis_tlast = out_evt.last;

endmodule

// ===== design/hbk_checker.sv =====
module hbk_checker import hbk_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Every item closes with a report-end or a disconnect, and nothing else does.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast ==
      (m_axis_tuser[2:0] == EV_END || m_axis_tuser[2:0] == EV_DISC)))
    else $error("tlast does not match event kind");

  a_usage_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2:0] != EV_UP && m_axis_tuser[2:0] != EV_DOWN
    |-> m_axis_tdata[7:0] == 8'h00)
    else $error("non-key event carries a usage");

  a_seen_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2:0] != EV_END |-> !m_axis_tdata[16])
    else $error("new press flag outside report end");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled item changed");

endmodule

bind hid_boot_report_key_event_differ hbk_checker u_hbk_checker (.*);
